/* rtl/srdz_pkg.sv */
// ----------------------------------------------------------------------------
// srdz_pkg
// Shared widths, reset values and sideband types for the radial dead zone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srdz_pkg;

  // Field and datapath widths
  localparam int unsigned AxisW = 9;   // signed stick / scaled fields
  localparam int unsigned MagW  = 9;   // |axis|, 0..256
  localparam int unsigned DzW   = 7;   // dead_zone register
  localparam int unsigned SumW  = 18;  // x*x + y*y
  localparam int unsigned RadW  = 34;  // (x*x + y*y) << 16
  localparam int unsigned RootW = 17;  // radius, 8 fraction bits
  localparam int unsigned NumW  = 33;  // mag * 128 * (m - edge)
  localparam int unsigned DenW  = 25;  // m * (128 - dead_zone)
  localparam int unsigned QW    = 9;   // quotient, top bit flags saturation

  // Register map
  localparam logic [DzW-1:0] DzReset     = 7'd30;
  localparam logic           IdxDeadZone = 1'b0;

  // Axis sign and magnitude, carried alongside the root pipeline
  typedef struct packed {
    logic            neg_x;
    logic            neg_y;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
  } axis_t;

  // Axis signs, carried alongside the divider
  typedef struct packed {
    logic neg_x;
    logic neg_y;
  } sign_t;

endpackage

/* rtl/srdz_in_if.sv */
// ----------------------------------------------------------------------------
// srdz_in_if
// Stick sample channel: valid/ready handshake with x and y deflection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srdz_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [srdz_pkg::AxisW-1:0]  stick_x;
  logic signed [srdz_pkg::AxisW-1:0]  stick_y;

  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

/* rtl/srdz_out_if.sv */
// ----------------------------------------------------------------------------
// srdz_out_if
// Scaled stick channel: valid/ready handshake with rescaled x and y.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srdz_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [srdz_pkg::AxisW-1:0]  scaled_x;
  logic signed [srdz_pkg::AxisW-1:0]  scaled_y;

  modport source (output valid, output scaled_x, output scaled_y, input ready);
  modport sink   (input valid, input scaled_x, input scaled_y, output ready);
endinterface

/* rtl/srdz_isqrt.sv */
// ----------------------------------------------------------------------------
// srdz_isqrt
// Pipelined floor square root, two result bits per stage, elastic stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdz_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [srdz_pkg::RadW-1:0]     rad_i,
  input  srdz_pkg::axis_t               side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [srdz_pkg::RootW-1:0]    root_o,
  output srdz_pkg::axis_t               side_o
);

  localparam int unsigned RadW   = srdz_pkg::RadW;
  localparam int unsigned RootW  = srdz_pkg::RootW;
  localparam int unsigned RemW   = RootW + 2;
  localparam int unsigned PerStg = 2;
  localparam int unsigned NStg   = (RootW + PerStg - 1) / PerStg;

  logic [NStg-1:0]  v_q;
  logic [NStg:0]    en;

  logic [RadW-1:0]  rad_q  [NStg];
  logic [RemW-1:0]  rem_q  [NStg];
  logic [RootW-1:0] root_q [NStg];
  srdz_pkg::axis_t  side_q [NStg];

  logic [RadW-1:0]  rad_d  [NStg];
  logic [RemW-1:0]  rem_d  [NStg];
  logic [RootW-1:0] root_d [NStg];

  logic [NStg-1:0]  src_v;
  logic [RadW-1:0]  src_rad  [NStg];
  logic [RemW-1:0]  src_rem  [NStg];
  logic [RootW-1:0] src_root [NStg];
  srdz_pkg::axis_t  src_side [NStg];

  // A stage may load when it is empty or its contents move on.
  always_comb begin : en_chain
    en[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin : stage_src
    src_v[0]    = valid_i;
    src_rad[0]  = rad_i;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_side[0] = side_i;
    for (int k = 1; k < NStg; k++) begin
      src_v[k]    = v_q[k-1];
      src_rad[k]  = rad_q[k-1];
      src_rem[k]  = rem_q[k-1];
      src_root[k] = root_q[k-1];
      src_side[k] = side_q[k-1];
    end
  end

  // Restoring digit recurrence: bring down two radicand bits, try 4*root+1.
  always_comb begin : root_steps
    logic [RadW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RemW+1:0]  rem_w;
    logic [RemW+1:0]  trial;
    for (int k = 0; k < NStg; k++) begin
      rad  = src_rad[k];
      rem  = src_rem[k];
      root = src_root[k];
      for (int s = 0; s < PerStg; s++) begin
        if (k * PerStg + s < RootW) begin
          rem_w = {rem, rad[RadW-1 -: 2]};
          trial = {2'b00, root, 2'b01};
          if (rem_w >= trial) begin
            rem_w = rem_w - trial;
            root  = {root[RootW-2:0], 1'b1};
          end else begin
            root  = {root[RootW-2:0], 1'b0};
          end
          rem = rem_w[RemW-1:0];
          rad = {rad[RadW-3:0], 2'b00};
        end
      end
      rad_d[k]  = rad;
      rem_d[k]  = rem;
      root_d[k] = root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= src_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= src_side[k];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];
  assign root_o  = root_q[NStg-1];
  assign side_o  = side_q[NStg-1];

endmodule

/* rtl/srdz_div.sv */
// ----------------------------------------------------------------------------
// srdz_div
// Two-lane pipelined restoring divider, nine quotient bits, two per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srdz_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [srdz_pkg::NumW-1:0]     num_x_i,
  input  logic [srdz_pkg::NumW-1:0]     num_y_i,
  input  logic [srdz_pkg::DenW-1:0]     den_i,
  input  srdz_pkg::sign_t               side_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [srdz_pkg::QW-1:0]       quo_x_o,
  output logic [srdz_pkg::QW-1:0]       quo_y_o,
  output srdz_pkg::sign_t               side_o
);

  localparam int unsigned NumW   = srdz_pkg::NumW;
  localparam int unsigned DenW   = srdz_pkg::DenW;
  localparam int unsigned QW     = srdz_pkg::QW;
  localparam int unsigned PerStg = 2;
  localparam int unsigned NStg   = (QW + PerStg - 1) / PerStg;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   en;

  logic [NumW-1:0] rx_q [NStg];
  logic [NumW-1:0] ry_q [NStg];
  logic [QW-1:0]   qx_q [NStg];
  logic [QW-1:0]   qy_q [NStg];
  logic [DenW-1:0] den_q  [NStg];
  srdz_pkg::sign_t side_q [NStg];

  logic [NumW-1:0] rx_d [NStg];
  logic [NumW-1:0] ry_d [NStg];
  logic [QW-1:0]   qx_d [NStg];
  logic [QW-1:0]   qy_d [NStg];

  logic [NStg-1:0] src_v;
  logic [NumW-1:0] src_rx [NStg];
  logic [NumW-1:0] src_ry [NStg];
  logic [QW-1:0]   src_qx [NStg];
  logic [QW-1:0]   src_qy [NStg];
  logic [DenW-1:0] src_den  [NStg];
  srdz_pkg::sign_t src_side [NStg];

  // One restoring step at quotient weight 2^sh; returns {rem, quotient}.
  function automatic logic [NumW+QW-1:0] div_step(
    input logic [NumW-1:0] rem,
    input logic [QW-1:0]   quo,
    input logic [DenW-1:0] den,
    input int unsigned     sh
  );
    logic [NumW:0] rem_w;
    logic [NumW:0] dsh;
    logic          ge;
    rem_w = {1'b0, rem};
    dsh   = {{(NumW + 1 - DenW){1'b0}}, den} << sh;
    ge    = (rem_w >= dsh);
    if (ge) begin
      rem_w = rem_w - dsh;
    end
    return {rem_w[NumW-1:0], quo[QW-2:0], ge};
  endfunction

  always_comb begin : en_chain
    en[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin : stage_src
    src_v[0]    = valid_i;
    src_rx[0]   = num_x_i;
    src_ry[0]   = num_y_i;
    src_qx[0]   = '0;
    src_qy[0]   = '0;
    src_den[0]  = den_i;
    src_side[0] = side_i;
    for (int k = 1; k < NStg; k++) begin
      src_v[k]    = v_q[k-1];
      src_rx[k]   = rx_q[k-1];
      src_ry[k]   = ry_q[k-1];
      src_qx[k]   = qx_q[k-1];
      src_qy[k]   = qy_q[k-1];
      src_den[k]  = den_q[k-1];
      src_side[k] = side_q[k-1];
    end
  end

  always_comb begin : div_steps
    logic [NumW+QW-1:0] sx;
    logic [NumW+QW-1:0] sy;
    for (int k = 0; k < NStg; k++) begin
      sx = {src_rx[k], src_qx[k]};
      sy = {src_ry[k], src_qy[k]};
      for (int s = 0; s < PerStg; s++) begin
        if (k * PerStg + s < QW) begin
          sx = div_step(sx[NumW+QW-1:QW], sx[QW-1:0], src_den[k],
                        QW - 1 - (k * PerStg + s));
          sy = div_step(sy[NumW+QW-1:QW], sy[QW-1:0], src_den[k],
                        QW - 1 - (k * PerStg + s));
        end
      end
      rx_d[k] = sx[NumW+QW-1:QW];
      qx_d[k] = sx[QW-1:0];
      ry_d[k] = sy[NumW+QW-1:QW];
      qy_d[k] = sy[QW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) begin
          v_q[k] <= src_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStg; k++) begin
      if (en[k]) begin
        rx_q[k]   <= rx_d[k];
        ry_q[k]   <= ry_d[k];
        qx_q[k]   <= qx_d[k];
        qy_q[k]   <= qy_d[k];
        den_q[k]  <= src_den[k];
        side_q[k] <= src_side[k];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NStg-1];
  assign quo_x_o = qx_q[NStg-1];
  assign quo_y_o = qy_q[NStg-1];
  assign side_o  = side_q[NStg-1];

endmodule

/* rtl/stick_radial_dead_zone_core.sv */
// ----------------------------------------------------------------------------
// stick_radial_dead_zone_core
// Each item passes through 18 register stages, A to E, before its result
// can be taken at the output.
// Throughput: one item per cycle while the consumer keeps taking results.
// Reset clears every stage valid bit and sets dead_zone to 30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Pipeline map (each stage is a register with its own valid bit):
//   A      : sign and magnitude of each axis
//   B      : x*x + y*y
//   R1..R9 : floor sqrt of the sum << 16, two root bits per stage
//   C      : dead-zone test, numerators mag*128*(m-edge), denominator m*span
//   D1..D5 : both axes divided, two quotient bits per stage
//   E      : saturate to 255, restore sign, output register
// Stages are elastic: a stage loads when it is empty or its item moves on,
// so bubbles are squeezed out and the input keeps taking items while a
// finished result waits at the output, until every stage is full.

module stick_radial_dead_zone_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  srdz_in_if.sink              sample_i,
  srdz_out_if.source           result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int unsigned AxisW = srdz_pkg::AxisW;
  localparam int unsigned MagW  = srdz_pkg::MagW;
  localparam int unsigned DzW   = srdz_pkg::DzW;
  localparam int unsigned SumW  = srdz_pkg::SumW;
  localparam int unsigned RadW  = srdz_pkg::RadW;
  localparam int unsigned RootW = srdz_pkg::RootW;
  localparam int unsigned NumW  = srdz_pkg::NumW;
  localparam int unsigned DenW  = srdz_pkg::DenW;
  localparam int unsigned QW    = srdz_pkg::QW;
  localparam int unsigned SpanW = 8;
  localparam int unsigned ProdW = MagW + RootW;  // mag * (m - edge)
  localparam int unsigned Depth = 18;            // register stages in total
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // --------------------------------------------------------------------------
  // Configuration: one register, dead_zone, at byte addresses 0 to 3 (paddr[2] == 0)
  // --------------------------------------------------------------------------
  logic [DzW-1:0] dz_q;
  logic           cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == srdz_pkg::IdxDeadZone);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= srdz_pkg::DzReset;
    end else if (cfg_wr) begin
      dz_q <= pwdata[DzW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == srdz_pkg::IdxDeadZone) ? {{(32 - DzW){1'b0}}, dz_q} : '0;

  // --------------------------------------------------------------------------
  // Handshake chain between the local stages and the two sub-pipelines
  // --------------------------------------------------------------------------
  logic a_v_q, b_v_q, c_v_q, e_v_q;
  logic en_a, en_b, en_c, en_e;
  logic sq_ready, sq_valid;
  logic dv_ready, dv_valid;

  assign en_e = !e_v_q || result_o.ready;
  assign en_c = !c_v_q || dv_ready;
  assign en_b = !b_v_q || sq_ready;
  assign en_a = !a_v_q || en_b;

  assign sample_i.ready = en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= sample_i.valid;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= sq_valid;
      if (en_e) e_v_q <= dv_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: sign/magnitude. -256 negates to 9'h100, read unsigned as 256.
  // --------------------------------------------------------------------------
  srdz_pkg::axis_t a_q;
  srdz_pkg::axis_t a_d;

  always_comb begin
    a_d.neg_x = sample_i.stick_x[AxisW-1];
    a_d.neg_y = sample_i.stick_y[AxisW-1];
    a_d.mag_x = a_d.neg_x ? MagW'(~sample_i.stick_x + 1'b1) : MagW'(sample_i.stick_x);
    a_d.mag_y = a_d.neg_y ? MagW'(~sample_i.stick_y + 1'b1) : MagW'(sample_i.stick_y);
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_q <= a_d;
  end

  // --------------------------------------------------------------------------
  // Stage B: sum of squares, at most 2^17, fits SumW bits
  // --------------------------------------------------------------------------
  logic [SumW-1:0] sqx, sqy, sum_q;
  srdz_pkg::axis_t b_q;

  assign sqx = {{(SumW - MagW){1'b0}}, a_q.mag_x} * {{(SumW - MagW){1'b0}}, a_q.mag_x};
  assign sqy = {{(SumW - MagW){1'b0}}, a_q.mag_y} * {{(SumW - MagW){1'b0}}, a_q.mag_y};

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      sum_q <= sqx + sqy;
      b_q   <= a_q;
    end
  end

  // --------------------------------------------------------------------------
  // Root pipeline: m = floor(sqrt(sum << 16)), 8 fraction bits
  // --------------------------------------------------------------------------
  logic [RootW-1:0] sq_root;
  srdz_pkg::axis_t  sq_side;

  srdz_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (b_v_q),
    .ready_o (sq_ready),
    .rad_i   ({sum_q, {(RadW - SumW){1'b0}}}),
    .side_i  (b_q),
    .valid_o (sq_valid),
    .ready_i (en_c),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // --------------------------------------------------------------------------
  // Stage C: dead-zone test and operands of the division.
  // Inside the zone the numerator is forced to 0 and the divisor to 1 so the
  // divider returns 0 (m may be 0 there, which would make m*span zero).
  // --------------------------------------------------------------------------
  logic [RootW-1:0] edge_c, diff_c;
  logic [SpanW-1:0] span_c;
  logic             below_c;
  logic [ProdW-1:0] px_c, py_c;
  logic [DenW-1:0]  den_c;

  logic [NumW-1:0]  numx_q, numy_q;
  logic [DenW-1:0]  den_q;
  srdz_pkg::sign_t  c_sign_q;

  assign edge_c  = {{(RootW - DzW - 8){1'b0}}, dz_q, 8'b0};
  assign below_c = (sq_root == '0) || (sq_root < edge_c);
  assign diff_c  = below_c ? '0 : (sq_root - edge_c);
  assign span_c  = 8'd128 - {{(SpanW - DzW){1'b0}}, dz_q};

  assign px_c = {{(ProdW - MagW){1'b0}}, sq_side.mag_x} * {{(ProdW - RootW){1'b0}}, diff_c};
  assign py_c = {{(ProdW - MagW){1'b0}}, sq_side.mag_y} * {{(ProdW - RootW){1'b0}}, diff_c};
  assign den_c = below_c ? DenW'(1)
               : ({{(DenW - RootW){1'b0}}, sq_root} * {{(DenW - SpanW){1'b0}}, span_c});

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      numx_q         <= {px_c, 7'b0};   // times 128
      numy_q         <= {py_c, 7'b0};
      den_q          <= den_c;
      c_sign_q.neg_x <= sq_side.neg_x;
      c_sign_q.neg_y <= sq_side.neg_y;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: 9-bit quotients, bit 8 set means the quotient is above 255
  // --------------------------------------------------------------------------
  logic [QW-1:0]   qx, qy;
  srdz_pkg::sign_t dv_sign;

  srdz_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v_q),
    .ready_o (dv_ready),
    .num_x_i (numx_q),
    .num_y_i (numy_q),
    .den_i   (den_q),
    .side_i  (c_sign_q),
    .valid_o (dv_valid),
    .ready_i (en_e),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .side_o  (dv_sign)
  );

  // --------------------------------------------------------------------------
  // Stage E: saturate, apply sign, hold for the consumer
  // --------------------------------------------------------------------------
  function automatic logic [AxisW-1:0] sat_sign(input logic [QW-1:0] q, input logic neg);
    logic [AxisW-1:0] val;
    val = {1'b0, (q[QW-1] ? 8'hFF : q[QW-2:0])};
    return neg ? AxisW'(~val + 1'b1) : val;
  endfunction

  logic signed [AxisW-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      ox_q <= sat_sign(qx, dv_sign.neg_x);
      oy_q <= sat_sign(qy, dv_sign.neg_y);
    end
  end

  assign result_o.valid    = e_v_q;
  assign result_o.scaled_x = ox_q;
  assign result_o.scaled_y = oy_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic [CntW-1:0] inflight_q, inflight_d;
  logic            take_in, take_out;

  assign take_in    = sample_i.valid && sample_i.ready;
  assign take_out   = result_o.valid && result_o.ready;
  assign inflight_d = inflight_q + {{(CntW - 1){1'b0}}, take_in}
                                 - {{(CntW - 1){1'b0}}, take_out};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Never more items in flight than there are stages.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(Depth))
    else $error("more items in flight than pipeline stages");

  // An empty output stage lets the whole chain advance.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> sample_i.ready)
    else $error("input stalled while output stage is empty");

  // Nothing comes out of an empty pipeline.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> !result_o.valid)
    else $error("result without an item in flight");

  // Saturation keeps results within -255..255.
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.scaled_x != -9'sd256) && (result_o.scaled_y != -9'sd256))
    else $error("result outside saturation range");

endmodule
